@@ hw/rtl/rar_pkg.sv @@
// Package: shared constants and types for rational arithmetic reduce block.
package rar_pkg;

	localparam int DEF_WIDTH = 32;

	localparam logic [2:0] OP_NORM = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic [2:0] {
		DP_LOAD   = 3'd0,
		DP_MUL1   = 3'd1,
		DP_MUL2   = 3'd2,
		DP_COMB   = 3'd3,
		DP_GSTART = 3'd4,
		DP_DSTART = 3'd5,
		DP_FINISH = 3'd6,
		DP_NONE   = 3'd7
	} dp_cmd_t;

	typedef struct packed {
		logic zero_den;
		logic zero_num;
		logic div_done;
		logic gcd_end;
	} dp_status_t;

endpackage

@@ hw/rtl/rar_datapath.sv @@
// Datapath: magnitudes, cross products, shared restoring divider for gcd and reduction.
module rar_datapath import rar_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [2:0]  op,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	output dp_status_t  stat,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic [1:0]  res_status
);
	logic [2:0]  op_q;
	logic [31:0] an_q, ad_q, bn_q, bd_q;
	logic        nega_q, negb_q, neg_q;
	logic [63:0] t1_q, t2_q, n_q, d_q;
	logic [63:0] x_q, y_q;
	// divider
	logic [63:0] dq_q, drem_q, dsor_q;
	logic [6:0]  dcnt_q;
	logic        dbusy_q;
	logic [1:0]  dmode_q; // 0 gcd step, 1 num reduce, 2 den reduce
	logic [31:0] rn_q;
	logic [30:0] rd_q;
	logic [1:0]  rs_q;
	logic [63:0] nred_q;

	function automatic logic [31:0] mag(input logic [31:0] v);
		mag = v[31] ? (32'd0 - v) : v;
	endfunction

	logic [2:0] opn;
	assign opn = (op > OP_DIV) ? OP_NORM : op;

	logic [64:0] trial;
	assign trial = {drem_q, dq_q[63]} - {1'b0, dsor_q};

	logic [63:0] lim;
	assign lim = 64'd1 << (WIDTH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			if (dbusy_q) begin
				if (!trial[64]) begin
					drem_q <= trial[63:0];
					dq_q   <= {dq_q[62:0], 1'b1};
				end else begin
					drem_q <= {drem_q[62:0], dq_q[63]};
					dq_q   <= {dq_q[62:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 7'd1;
				if (dcnt_q == 7'd1) dbusy_q <= 1'b0;
			end
			unique case (cmd)
				DP_GSTART: begin
					dbusy_q <= 1'b1; dcnt_q <= 7'd64; dmode_q <= 2'd0;
					dq_q <= x_q; drem_q <= '0; dsor_q <= y_q;
				end
				DP_DSTART: begin
					dbusy_q <= 1'b1; dcnt_q <= 7'd64;
					if (dmode_q == 2'd0) begin
						dmode_q <= 2'd1; dq_q <= n_q;
					end else begin
						dmode_q <= 2'd2; dq_q <= d_q; nred_q <= dq_q;
					end
					drem_q <= '0; dsor_q <= x_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			DP_LOAD: begin
				op_q   <= opn;
				an_q   <= mag(a_num);
				ad_q   <= mag(a_den);
				bn_q   <= mag(b_num);
				bd_q   <= mag(b_den);
				nega_q <= a_num[31] ^ a_den[31];
				negb_q <= (b_num[31] ^ b_den[31]) ^ (opn == OP_SUB);
			end
			DP_MUL1: begin
				unique case (op_q)
					OP_MUL:  t1_q <= 64'(an_q) * 64'(bn_q);
					default: t1_q <= 64'(an_q) * 64'(bd_q);
				endcase
				t2_q <= 64'(bn_q) * 64'(ad_q);
			end
			DP_MUL2: begin
				unique case (op_q)
					OP_DIV:  d_q <= 64'(ad_q) * 64'(bn_q);
					default: d_q <= 64'(ad_q) * 64'(bd_q);
				endcase
			end
			DP_COMB: begin
				unique case (op_q)
					OP_ADD, OP_SUB: begin
						if (nega_q == negb_q) begin
							n_q <= t1_q + t2_q; neg_q <= nega_q;
						end else if (t1_q >= t2_q) begin
							n_q <= t1_q - t2_q; neg_q <= nega_q;
						end else begin
							n_q <= t2_q - t1_q; neg_q <= negb_q;
						end
					end
					OP_MUL, OP_DIV: begin
						n_q <= t1_q; neg_q <= nega_q ^ negb_q;
					end
					default: begin
						n_q <= 64'(an_q); d_q <= 64'(ad_q); neg_q <= nega_q;
					end
				endcase
			end
			DP_FINISH: begin
				if (stat.zero_den) begin
					rn_q <= '0; rd_q <= '0; rs_q <= ST_ZERO_DEN;
				end else if (stat.zero_num) begin
					rn_q <= '0; rd_q <= 31'd1; rs_q <= ST_OK;
				end else if (dq_q > lim - 64'd1 ||
					nred_q > (neg_q ? lim : lim - 64'd1)) begin
					rn_q <= '0; rd_q <= '0; rs_q <= ST_OVERFLOW;
				end else begin
					rn_q <= neg_q ? (32'd0 - nred_q[31:0]) : nred_q[31:0];
					rd_q <= dq_q[30:0];
					rs_q <= ST_OK;
				end
			end
			default: ;
		endcase
		// gcd: the combine command seeds x,y from n,d; after each mod step shift
		if (cmd == DP_COMB) begin
			x_q <= (op_q == OP_NORM) ? 64'(an_q) :
				(op_q == OP_ADD || op_q == OP_SUB) ?
				((nega_q == negb_q) ? t1_q + t2_q :
				 (t1_q >= t2_q) ? t1_q - t2_q : t2_q - t1_q) : t1_q;
			y_q <= (op_q == OP_NORM) ? 64'(ad_q) : d_q;
		end else if (cmd == DP_NONE && dmode_q == 2'd0 && stat.div_done && !stat.gcd_end
			&& dcnt_q == '0 && y_q != '0 && dsor_q == y_q) begin
			x_q <= y_q;
			y_q <= drem_q;
		end
	end

	// div_done is high while the divider is idle; gcd_end when y is zero
	assign stat.div_done = !dbusy_q;
	assign stat.gcd_end  = (y_q == '0);
	assign stat.zero_den = (ad_q == '0) || (op_q != OP_NORM && bd_q == '0) ||
		(op_q == OP_DIV && bn_q == '0);
	assign stat.zero_num = (n_q == '0);

	assign res_num    = rn_q;
	assign res_den    = rd_q;
	assign res_status = rs_q;
endmodule

@@ hw/rtl/rar_ctrl.sv @@
// Controller: sequences load, products, gcd loop, two reductions, output handshake.
module rar_ctrl import rar_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t stat,
	output dp_cmd_t    cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_MUL1  = 10'b0000000010,
		S_MUL2  = 10'b0000000100,
		S_COMB  = 10'b0000001000,
		S_GCHK  = 10'b0000010000,
		S_GWAIT = 10'b0000100000,
		S_NRED  = 10'b0001000000,
		S_DRED  = 10'b0010000000,
		S_FIN   = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   gstep_q; // a divider start (gcd mod step or reduction) has been issued

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = DP_NONE;
		unique case (state_q)
			S_IDLE: if (in_valid) begin cmd = DP_LOAD; state_d = S_MUL1; end
			S_MUL1: begin cmd = DP_MUL1; state_d = S_MUL2; end
			S_MUL2: begin cmd = DP_MUL2; state_d = S_COMB; end
			S_COMB: begin cmd = DP_COMB; state_d = S_GCHK; end
			S_GCHK: begin
				if (stat.zero_den || stat.zero_num) state_d = S_FIN;
				else if (stat.gcd_end) begin cmd = DP_DSTART; state_d = S_NRED; end
				else begin cmd = DP_GSTART; state_d = S_GWAIT; end
			end
			S_GWAIT: if (stat.div_done && gstep_q) state_d = S_GCHK;
			S_NRED: if (stat.div_done && gstep_q) begin
				cmd = DP_DSTART; state_d = S_DRED;
			end
			S_DRED: if (stat.div_done && gstep_q) state_d = S_FIN;
			S_FIN: begin cmd = DP_FINISH; state_d = S_OUT; end
			S_OUT: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gstep_q <= 1'b0;
		end else begin
			state_q <= state_d;
			gstep_q <= (cmd == DP_GSTART || cmd == DP_DSTART) ? 1'b1 :
				(state_d != state_q) ? 1'b0 : gstep_q;
		end
	end
endmodule

@@ hw/rtl/rational_arith_reduce_top.sv @@
// Top level: rational arithmetic with gcd reduction.
// Zero-numerator and zero-denominator cases skip the gcd and reductions.
// Throughput: one transaction at a time; the controller returns to idle the cycle after
// the result is taken and accepts the next input from then on.
// The shared 64-bit restoring divider (one quotient bit per cycle) sets the rate.
// Reset: arst_n async low returns the controller to idle, no result pending.
module rational_arith_reduce_top import rar_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic [1:0]  status
);
	dp_cmd_t    cmd;
	dp_status_t stat;

	// controller issues one command per cycle; datapath reports status
	rar_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.stat, .cmd
	);

	// datapath holds the result registers stable while out_valid is high
	rar_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk, .arst_n, .cmd, .op, .a_num, .a_den, .b_num, .b_den,
		.stat, .res_num, .res_den, .res_status(status)
	);
endmodule

@@ hw/rtl/rar_checker.sv @@
// Checker: port-level assertions for the rational reduce top level.
module rar_checker import rar_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] res_num,
	input logic [30:0] res_den,
	input logic [1:0]  status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_num))
		else $error("result changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> res_num == '0 && res_den == '0)
		else $error("error result not zeroed");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status code");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("block not busy after accepting a transaction");
endmodule

bind rational_arith_reduce_top rar_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.res_num, .res_den, .status
);
